// ===== sv/gps_inertial_position_integrator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the position integrator
// Clocked concurrent checks, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef GPS_INERTIAL_POSITION_INTEGRATOR_ASSERT_SVH
`define GPS_INERTIAL_POSITION_INTEGRATOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define GIPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define GIPI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/gipi_pkg.sv =====
// ---------------------------------------------------------------------------
// gipi_pkg
// Constants and types of the GPS-aided inertial position integrator.
// ---------------------------------------------------------------------------
package gipi_pkg;

    localparam int CORR_SHIFT  = 8;
    localparam int AXES        = 3;
    localparam int AXIS_SLOTS  = 3;
    localparam int AXIS_W      = 2;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 152;
    localparam int OUT_DATA_W  = 192;

    localparam logic signed [15:0] ACCEL_GAIN_RST  = 16'sd0;
    localparam logic signed [15:0] VP_GAIN_RST     = 16'sd0;
    localparam logic signed [15:0] FILTER_GAIN_RST = 16'sd16777;
    localparam logic        [15:0] TAU_INV_RST     = 16'd26214;
    localparam logic        [14:0] DR_PERIOD_RST   = 15'd110;
    localparam logic        [15:0] COUNTDOWN_RST   = 16'd110;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACCEL_GAIN  = 3'd0,
        CFG_VP_GAIN     = 3'd1,
        CFG_FILTER_GAIN = 3'd2,
        CFG_TAU_INV     = 3'd3,
        CFG_DR_PERIOD   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_ACC_VEL = 3'd0,
        OP_VEL_POS = 3'd1,
        OP_FG_VEL  = 3'd2,
        OP_FG_POS  = 3'd3,
        OP_TAU     = 3'd4
    } op_t;

endpackage

// ===== sv/gps_inertial_position_integrator.sv =====
// A disabled tick goes from ST_IDLE straight to ST_DONE. An enabled tick works through the axes;
// each product takes an ST_MUL and an ST_ACC state: OP_ACC_VEL and OP_VEL_POS, and with
// correction also OP_FG_VEL, OP_FG_POS and OP_TAU, plus an ST_CAPT state per axis on a GPS
// capture; ST_DONE then hands the result over to the output register. One tick is worked on
// at a time through the single shared 17x17 multiplier; the next tick is taken once the result
// sits in the output register. Reset (rst_n, asynchronous, active low) restores gains and a countdown of 110.
// ---------------------------------------------------------------------------
// gps_inertial_position_integrator
// Dead-reckoning velocity and position integrators with GPS error correction.
// ---------------------------------------------------------------------------
`include "gps_inertial_position_integrator_assert.svh"

module gps_inertial_position_integrator
    import gipi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Tick input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, lowest bit up: enable, accel_x, accel_y, accel_z, gps_request,
    // gps_valid, gps_pos_x, gps_pos_y, gps_pos_z, gps_vel_x, gps_vel_y, gps_vel_z, zero fill.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, lowest bit up: vel_out_x, vel_out_y, vel_out_z, pos_out_x, pos_out_y, pos_out_z.
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // The sequencer walks the axes in turn. For each axis every product goes through
    // the one multiplier in an ST_MUL cycle and is folded into the integrators or the
    // velocity estimate in the following ST_ACC cycle. A GPS capture adds an ST_CAPT state
    // at the end of each axis, after that axis has been fully integrated and corrected.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CAPT,
        ST_DONE
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic [AXIS_W-1:0] axis_reg;
    logic   corr_reg;
    logic   capture_go_reg;

    // Configuration registers.
    logic signed [15:0] accel_gain_reg;
    logic signed [15:0] vp_gain_reg;
    logic signed [15:0] filter_gain_reg;
    logic        [15:0] tau_inv_reg;
    logic        [14:0] dr_period_reg;

    // Filter state.
    logic [31:0] vel_int_reg [AXIS_SLOTS];
    logic [31:0] pos_int_reg [AXIS_SLOTS];
    logic [31:0] vel_est_reg [AXIS_SLOTS];
    logic [15:0] pos_err_reg [AXIS_SLOTS];
    logic [15:0] vel_err_reg [AXIS_SLOTS];
    logic [15:0] countdown_reg;
    logic        pending_reg;

    // Captured payload of the tick being worked on.
    logic signed [15:0] accel_reg   [AXIS_SLOTS];
    logic        [15:0] gps_pos_reg [AXIS_SLOTS];
    logic        [15:0] gps_vel_reg [AXIS_SLOTS];

    logic signed [33:0] prod_reg;
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Fields of the incoming transfer.
    logic        in_enable;
    logic        in_request;
    logic        in_valid;
    logic        pending_next;
    logic [15:0] in_accel [AXIS_SLOTS];
    logic [15:0] in_pos   [AXIS_SLOTS];
    logic [15:0] in_vel   [AXIS_SLOTS];

    assign in_enable  = s_tdata[0];
    assign in_request = s_tdata[49];
    assign in_valid   = s_tdata[50];
    assign pending_next = pending_reg | in_request;

    always_comb
    begin
        for (int a = 0; a < AXIS_SLOTS; a++)
        begin
            in_accel[a] = s_tdata[1 + 16*a +: 16];
            in_pos[a]   = s_tdata[51 + 16*a +: 16];
            in_vel[a]   = s_tdata[99 + 16*a +: 16];
        end
    end

    // Shared multiplier. Both operands are widened to 17 bits so that the unsigned
    // tau_inv gain and the signed gains go through the same signed product.
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;

    always_comb
    begin
        unique case (op_reg)
            OP_ACC_VEL:
            begin
                mul_a = 17'(accel_gain_reg);
                mul_b = 17'(accel_reg[axis_reg]);
            end
            OP_VEL_POS:
            begin
                mul_a = 17'(vp_gain_reg);
                mul_b = 17'(signed'(vel_int_reg[axis_reg][31:16]));
            end
            OP_FG_VEL:
            begin
                mul_a = 17'(filter_gain_reg);
                mul_b = 17'(signed'(vel_err_reg[axis_reg]));
            end
            OP_FG_POS:
            begin
                mul_a = 17'(filter_gain_reg);
                mul_b = 17'(signed'(pos_err_reg[axis_reg]));
            end
            OP_TAU:
            begin
                mul_a = signed'({1'b0, tau_inv_reg});
                mul_b = 17'(signed'(pos_err_reg[axis_reg]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Products of two signed 16-bit values fit in 32 bits, so the arithmetic shift of
    // the 34-bit product truncated to 32 bits wraps exactly as the filter requires.
    logic signed [33:0] prod_shifted;
    logic        [31:0] prod_lo;
    logic        [31:0] prod_sh;
    logic               last_axis;
    logic               handover;

    assign prod_shifted = prod_reg >>> CORR_SHIFT;
    assign prod_sh      = prod_shifted[31:0];
    assign prod_lo      = prod_reg[31:0];
    assign last_axis    = (axis_reg == AXIS_W'(AXES - 1));

    // The finished tick moves into the output register once it is free or being emptied.
    assign handover = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_ACC_VEL;
            axis_reg        <= '0;
            corr_reg        <= 1'b0;
            capture_go_reg  <= 1'b0;
            accel_gain_reg  <= ACCEL_GAIN_RST;
            vp_gain_reg     <= VP_GAIN_RST;
            filter_gain_reg <= FILTER_GAIN_RST;
            tau_inv_reg     <= TAU_INV_RST;
            dr_period_reg   <= DR_PERIOD_RST;
            for (int a = 0; a < AXIS_SLOTS; a++)
            begin
                vel_int_reg[a] <= '0;
                pos_int_reg[a] <= '0;
                vel_est_reg[a] <= '0;
                pos_err_reg[a] <= '0;
                vel_err_reg[a] <= '0;
            end
            countdown_reg   <= COUNTDOWN_RST;
            pending_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_ACCEL_GAIN:  accel_gain_reg  <= signed'(cfg_wdata);
                    CFG_VP_GAIN:     vp_gain_reg     <= signed'(cfg_wdata);
                    CFG_FILTER_GAIN: filter_gain_reg <= signed'(cfg_wdata);
                    CFG_TAU_INV:     tau_inv_reg     <= cfg_wdata;
                    CFG_DR_PERIOD:   dr_period_reg   <= cfg_wdata[14:0];
                    default:         ;
                endcase
            end

            if (handover)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int a = 0; a < AXIS_SLOTS; a++)
                        begin
                            accel_reg[a]   <= signed'(in_accel[a]);
                            gps_pos_reg[a] <= in_pos[a];
                            gps_vel_reg[a] <= in_vel[a];
                        end
                        axis_reg <= '0;
                        op_reg   <= OP_ACC_VEL;
                        if (in_enable)
                        begin
                            // The countdown is sampled before any reload, and a capture
                            // taken in this tick overrides the decrement.
                            corr_reg       <= (countdown_reg != '0);
                            capture_go_reg <= in_valid && pending_next;
                            if (in_valid && pending_next)
                            begin
                                pending_reg   <= 1'b0;
                                countdown_reg <= {1'b0, dr_period_reg};
                            end
                            else
                            begin
                                pending_reg <= pending_next;
                                if (countdown_reg != '0)
                                begin
                                    countdown_reg <= countdown_reg - 16'd1;
                                end
                            end
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            // Disabled: the integrators clear, a request still arms the capture, everything else holds.
                            pending_reg <= pending_next;
                            for (int a = 0; a < AXIS_SLOTS; a++)
                            begin
                                vel_int_reg[a] <= '0;
                                pos_int_reg[a] <= '0;
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                end

                ST_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end

                ST_ACC:
                begin
                    unique case (op_reg)
                        OP_ACC_VEL:
                        begin
                            vel_int_reg[axis_reg] <= vel_int_reg[axis_reg] + prod_lo;
                            op_reg    <= OP_VEL_POS;
                            state_reg <= ST_MUL;
                        end
                        OP_VEL_POS:
                        begin
                            pos_int_reg[axis_reg] <= pos_int_reg[axis_reg] + prod_sh;
                            if (corr_reg)
                            begin
                                op_reg    <= OP_FG_VEL;
                                state_reg <= ST_MUL;
                            end
                            else
                            begin
                                vel_est_reg[axis_reg] <= vel_int_reg[axis_reg];
                                op_reg <= OP_ACC_VEL;
                                if (capture_go_reg)
                                begin
                                    state_reg <= ST_CAPT;
                                end
                                else if (last_axis)
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    axis_reg  <= axis_reg + AXIS_W'(1);
                                    state_reg <= ST_MUL;
                                end
                            end
                        end
                        OP_FG_VEL:
                        begin
                            vel_int_reg[axis_reg] <= vel_int_reg[axis_reg] + prod_sh;
                            op_reg    <= OP_FG_POS;
                            state_reg <= ST_MUL;
                        end
                        OP_FG_POS:
                        begin
                            pos_int_reg[axis_reg] <= pos_int_reg[axis_reg] + prod_sh;
                            op_reg    <= OP_TAU;
                            state_reg <= ST_MUL;
                        end
                        OP_TAU:
                        begin
                            vel_est_reg[axis_reg] <= vel_int_reg[axis_reg] + prod_lo;
                            op_reg <= OP_ACC_VEL;
                            if (capture_go_reg)
                            begin
                                state_reg <= ST_CAPT;
                            end
                            else if (last_axis)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                axis_reg  <= axis_reg + AXIS_W'(1);
                                state_reg <= ST_MUL;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end

                ST_CAPT:
                begin
                    // New errors are the GPS figures minus the high words, wrapping.
                    pos_err_reg[axis_reg] <= gps_pos_reg[axis_reg]
                                             - pos_int_reg[axis_reg][31:16];
                    vel_err_reg[axis_reg] <= gps_vel_reg[axis_reg]
                                             - vel_int_reg[axis_reg][31:16];
                    if (last_axis)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + AXIS_W'(1);
                        state_reg <= ST_MUL;
                    end
                end

                ST_DONE:
                begin
                    // Hand over once the output register is free or being emptied.
                    if (handover)
                    begin
                        for (int a = 0; a < AXIS_SLOTS; a++)
                        begin
                            m_tdata_reg[32*a +: 32]      <= vel_est_reg[a];
                            m_tdata_reg[96 + 32*a +: 32] <= pos_int_reg[a];
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `GIPI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input accepted while a tick was still in progress")
    `GIPI_ASSERT_NOW(a_capture_only_when_armed, state_reg == ST_CAPT, capture_go_reg,
        "error capture entered without a pending valid GPS fix")
    `GIPI_ASSERT_NOW(a_correction_ops_armed,
        (state_reg == ST_ACC) && (op_reg == OP_FG_VEL || op_reg == OP_FG_POS || op_reg == OP_TAU),
        corr_reg, "correction product applied while the countdown had expired")
    `GIPI_ASSERT_NOW(a_axis_in_range, state_reg != ST_IDLE, axis_reg < AXIS_W'(AXES),
        "axis counter beyond the configured number of axes")

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// Testbench for gps_inertial_position_integrator
// Drives heartbeat ticks into the integrator over its input stream and
// checks every navigation estimate that leaves the output stream against
// a cycle-free predictor of the three-axis dead-reckoning filter, or a
// typed-in answer. A short table of directed ticks comes first, then phases
// of random ticks under changing gains and changing amounts of idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
    import gipi_pkg::*;

    // This covers a tick in flight plus the hand-over into the output register.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_TICKS   = 235;

    // One heartbeat tick as it is packed into s_tdata.
    typedef struct {
        logic        enable;
        logic [15:0] accel [3];
        logic        gps_request;
        logic        gps_valid;
        logic [15:0] gps_pos [3];
        logic [15:0] gps_vel [3];
    } tick_t;

    // One navigation estimate as it is packed into m_tdata.
    typedef struct {
        logic [31:0] vel [3];
        logic [31:0] pos [3];
    } nav_t;

    // A row of the directed table is either a tick or a register write.
    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_idx_t    idx;
        logic [15:0] value;
        tick_t       tick;
        bit          typed;
        nav_t        want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    gps_inertial_position_integrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // -----------------------------------------------------------------------
    // Predictor state: the gains as last written and the filter's own
    // integrators, errors and correction countdown, all at their reset values.
    // -----------------------------------------------------------------------
    logic [15:0] g_accel   = ACCEL_GAIN_RST;
    logic [15:0] g_vel_pos = VP_GAIN_RST;
    logic [15:0] g_filter  = FILTER_GAIN_RST;
    logic [15:0] g_tau     = TAU_INV_RST;
    logic [14:0] dr_ticks  = DR_PERIOD_RST;

    logic [31:0] vel_acc [3] = '{default: '0};
    logic [31:0] pos_acc [3] = '{default: '0};
    logic [31:0] vel_est [3] = '{default: '0};
    logic [15:0] pos_err [3] = '{default: '0};
    logic [15:0] vel_err [3] = '{default: '0};
    logic [15:0] corr_count  = COUNTDOWN_RST;
    logic        capture_armed = 1'b0;

    // Estimates predicted for accepted ticks, oldest first.
    nav_t nav_due [$];

    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_request = 0;

    string axis_name [3] = '{"x", "y", "z"};

    function automatic longint signed16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    // One tick of the filter. The request flag arms the capture before
    // anything else, so a tick carrying both request and valid GPS captures
    // at once. The errors are taken from the integrals after this tick's
    // integration and correction. A disabled tick clears only the two
    // integrals; the velocity estimate, the errors and the countdown hold,
    // and a request still arms the capture.
    function automatic nav_t integrate_tick(tick_t t);
        nav_t   est;
        longint p;
        longint q;
        bit     correcting;
        if (t.gps_request)
            capture_armed = 1'b1;
        if (t.enable)
        begin
            correcting = (corr_count != 0);
            if (correcting)
                corr_count = corr_count - 16'd1;
            for (int a = 0; a < AXES; a++)
            begin
                p = signed16(g_accel) * signed16(t.accel[a]);
                vel_acc[a] += p[31:0];
                p = signed16(g_vel_pos) * signed16(vel_acc[a][31:16]);
                q = p >>> CORR_SHIFT;
                pos_acc[a] += q[31:0];
                if (correcting)
                begin
                    p = signed16(g_filter) * signed16(vel_err[a]);
                    q = p >>> CORR_SHIFT;
                    vel_acc[a] += q[31:0];
                    p = signed16(g_filter) * signed16(pos_err[a]);
                    q = p >>> CORR_SHIFT;
                    pos_acc[a] += q[31:0];
                    // tau_inv is unsigned, the position error signed.
                    p = longint'({48'd0, g_tau}) * signed16(pos_err[a]);
                    vel_est[a] = vel_acc[a] + p[31:0];
                end
                else
                begin
                    vel_est[a] = vel_acc[a];
                end
            end
            if (t.gps_valid && capture_armed)
            begin
                capture_armed = 1'b0;
                corr_count    = {1'b0, dr_ticks};
                for (int a = 0; a < AXES; a++)
                begin
                    pos_err[a] = t.gps_pos[a] - pos_acc[a][31:16];
                    vel_err[a] = t.gps_vel[a] - vel_acc[a][31:16];
                end
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                vel_acc[a] = '0;
                pos_acc[a] = '0;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            est.vel[a] = vel_est[a];
            est.pos[a] = pos_acc[a];
        end
        return est;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tick(tick_t t);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[0] = t.enable;
        for (int a = 0; a < 3; a++)
        begin
            d[1 + 16*a +: 16]   = t.accel[a];
            d[51 + 16*a +: 16]  = t.gps_pos[a];
            d[99 + 16*a +: 16]  = t.gps_vel[a];
        end
        d[49] = t.gps_request;
        d[50] = t.gps_valid;
        return d;
    endfunction

    function automatic tick_t make_tick(logic en, logic [15:0] ax, logic [15:0] ay,
                                        logic [15:0] az, logic req, logic val,
                                        logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                        logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
        tick_t t;
        t.enable      = en;
        t.accel       = '{ax, ay, az};
        t.gps_request = req;
        t.gps_valid   = val;
        t.gps_pos     = '{px, py, pz};
        t.gps_vel     = '{vx, vy, vz};
        return t;
    endfunction

    function automatic row_t tick_row(tick_t t, bit typed, nav_t want);
        row_t r;
        r.kind  = ROW_TICK;
        r.idx   = CFG_ACCEL_GAIN;
        r.value = '0;
        r.tick  = t;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t cfg_row(cfg_idx_t idx, logic [15:0] v);
        row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = v;
        r.typed = 1'b0;
        return r;
    endfunction

    // Random ticks: mostly enabled, with GPS requests often enough that
    // captures and correction runs keep coming, and valid GPS most of the time.
    function automatic tick_t rand_tick();
        tick_t t;
        t.enable      = ($urandom_range(99) < 92);
        t.gps_request = ($urandom_range(99) < 15);
        t.gps_valid   = ($urandom_range(99) < 70);
        for (int a = 0; a < 3; a++)
        begin
            t.accel[a]   = 16'($urandom_range(16'hFFFF));
            t.gps_pos[a] = 16'($urandom_range(16'hFFFF));
            t.gps_vel[a] = 16'($urandom_range(16'hFFFF));
        end
        return t;
    endfunction

    // A signed gain, at one of its extremes now and then.
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // -----------------------------------------------------------------------
    // Register writes. The write enable is left high so that writes can
    // follow one another on consecutive cycles; the caller lowers it.
    // -----------------------------------------------------------------------
    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_ACCEL_GAIN:  g_accel   = v;
            CFG_VP_GAIN:     g_vel_pos = v;
            CFG_FILTER_GAIN: g_filter  = v;
            CFG_TAU_INV:     g_tau     = v;
            CFG_DR_PERIOD:   dr_ticks  = v[14:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Stops offering ticks, waits for every predicted estimate and lets the
    // block settle, so that registers are only ever written while it idles.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (nav_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Offers one tick, entered and left at a falling edge. Optional idle
    // cycles come first; the transfer completes at the first rising edge
    // that sees s_tready high, and only then is the tick fed to the predictor.
    task automatic send_tick(tick_t t, bit typed, nav_t want);
        nav_t est;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_tick(t);
        do
            @(posedge clk);
        while (!s_tready);
        est = integrate_tick(t);
        // Rows of the directed table with a typed-in answer are checked
        // against that answer; the predictor still steps to keep its state.
        nav_due.push_back(typed ? want : est);
        @(negedge clk);
    endtask

    task automatic check_estimate(logic [OUT_DATA_W-1:0] d);
        nav_t want;
        logic [31:0] got;
        if (nav_due.size() == 0)
        begin
            report_mismatch($sformatf("estimate 0x%h with nothing expected", d));
            return;
        end
        want = nav_due.pop_front();
        for (int a = 0; a < 3; a++)
        begin
            got = d[32*a +: 32];
            if (got !== want.vel[a])
                report_mismatch($sformatf("vel_out_%s got 0x%h expected 0x%h",
                                          axis_name[a], got, want.vel[a]));
            got = d[96 + 32*a +: 32];
            if (got !== want.pos[a])
                report_mismatch($sformatf("pos_out_%s got 0x%h expected 0x%h",
                                          axis_name[a], got, want.pos[a]));
        end
    endtask

    // -----------------------------------------------------------------------
    // Clock.
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Result side. m_tready changes at the falling edge only. A hold-off
    // request from the stimulus is counted down here, so the receiver stays
    // away for a long stretch while the sender keeps offering ticks.
    // -----------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Every transfer on the result stream is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_estimate(m_tdata);
    end

    // -----------------------------------------------------------------------
    // Stimulus.
    // -----------------------------------------------------------------------
    initial
    begin
        row_t directed [$];
        nav_t zero_nav;
        nav_t coast_nav;
        bit   cfg_open;

        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_ACCEL_GAIN;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        zero_nav  = '{vel: '{default: '0}, pos: '{default: '0}};
        // Unit acceleration gain with the correction errors still zero:
        // the velocity is the sign-extended acceleration itself.
        coast_nav = '{vel: '{32'h0000_7FFF, 32'hFFFF_8000, 32'h0}, pos: '{default: '0}};

        // Straight after reset the acceleration and velocity-to-position gains and
        // the errors are zero, so an enabled tick and a disabled one both report all zeros.
        directed.push_back(tick_row(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1, zero_nav));
        directed.push_back(tick_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1, zero_nav));
        directed.push_back(cfg_row(CFG_ACCEL_GAIN, 16'h0001));
        directed.push_back(tick_row(make_tick(1, 16'h7FFF, 16'h8000, 0, 0, 0,
                                              0, 0, 0, 0, 0, 0), 1, coast_nav));
        // Disabled: integrals clear, the velocity estimate holds.
        directed.push_back(tick_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1, coast_nav));

        // Gains at their extremes and a short correction run.
        directed.push_back(cfg_row(CFG_ACCEL_GAIN,  16'h7FFF));
        directed.push_back(cfg_row(CFG_VP_GAIN,     16'h7FFF));
        directed.push_back(cfg_row(CFG_FILTER_GAIN, 16'h8000));
        directed.push_back(cfg_row(CFG_TAU_INV,     16'hFFFF));
        directed.push_back(cfg_row(CFG_DR_PERIOD,   16'd3));
        directed.push_back(tick_row(make_tick(1, 16'h8000, 16'h8000, 16'h8000, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        // Request with invalid GPS: the capture waits.
        directed.push_back(tick_row(make_tick(1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0,
                                              16'h1111, 16'h2222, 16'h3333,
                                              16'h4444, 16'h5555, 16'h6666), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h1234, 16'h8000, 16'h7FFF, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        // Valid GPS arrives later and captures with extreme positions.
        directed.push_back(tick_row(make_tick(1, 0, 0, 0, 0, 1,
                                              16'h7FFF, 16'h8000, 16'h5555,
                                              16'h8000, 16'h7FFF, 16'hAAAA), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h0100, 16'hFF00, 16'h0001, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'hFFFF, 16'h0001, 16'h8001, 0, 1,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h4000, 16'hC000, 16'h0000, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        // Countdown has run out: no correction on this one.
        directed.push_back(tick_row(make_tick(1, 16'h2000, 16'hE000, 16'h7FFF, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        // A request while disabled only arms the capture.
        directed.push_back(tick_row(make_tick(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1,
                                              16'h7FFF, 16'h7FFF, 16'h7FFF,
                                              16'h7FFF, 16'h7FFF, 16'h7FFF), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h0010, 16'h0020, 16'h0030, 0, 1,
                                              16'hFFFF, 16'h0000, 16'h8000,
                                              16'h0001, 16'hFFFF, 16'h7FFF), 0, zero_nav));
        // Request and valid GPS on the same tick capture at once.
        directed.push_back(tick_row(make_tick(1, 16'h8000, 16'h7FFF, 16'h8000, 1, 1,
                                              16'h8000, 16'h7FFF, 16'h0000,
                                              16'h7FFF, 16'h8000, 16'hFFFF), 0, zero_nav));

        // Opposite extremes and a zero period: a capture starts no correction.
        directed.push_back(cfg_row(CFG_ACCEL_GAIN,  16'h8000));
        directed.push_back(cfg_row(CFG_VP_GAIN,     16'h8000));
        directed.push_back(cfg_row(CFG_FILTER_GAIN, 16'h7FFF));
        directed.push_back(cfg_row(CFG_TAU_INV,     16'h0000));
        directed.push_back(cfg_row(CFG_DR_PERIOD,   16'h0000));
        directed.push_back(tick_row(make_tick(1, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 1,
                                              16'h7FFF, 16'h7FFF, 16'h8000,
                                              16'h8000, 16'h8000, 16'h7FFF), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h8000, 16'h8000, 16'h7FFF, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));

        // Longest period; the top data bit of this 15-bit register is dropped.
        directed.push_back(cfg_row(CFG_DR_PERIOD, 16'hFFFF));
        directed.push_back(cfg_row(CFG_TAU_INV,   16'hFFFF));
        directed.push_back(tick_row(make_tick(1, 16'h0001, 16'hFFFF, 16'h0000, 1, 1,
                                              16'h5555, 16'hAAAA, 16'h0F0F,
                                              16'hF0F0, 16'h3C3C, 16'hC3C3), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h7FFF, 16'h7FFF, 16'h8000, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        directed.push_back(tick_row(make_tick(1, 16'h8000, 16'h0001, 16'h7FFF, 0, 1,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));
        directed.push_back(tick_row(make_tick(0, 16'h1234, 16'h5678, 16'h9ABC, 0, 0,
                                              0, 0, 0, 0, 0, 0), 0, zero_nav));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table with no idling on either side. Register
        // rows are only reached once the block has gone quiet.
        cfg_open = 0;
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    drain_and_settle();
                write_reg(directed[i].idx, directed[i].value);
                cfg_open = 1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_we   <= 1'b0;
                    cfg_open = 0;
                end
                send_tick(directed[i].tick, directed[i].typed, directed[i].want);
            end
        end

        // Random phases: fresh gains each time, idling cycling through none,
        // sender only, receiver only and both.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_and_settle();
            write_reg(CFG_ACCEL_GAIN,  pick_gain());
            write_reg(CFG_VP_GAIN,     pick_gain());
            write_reg(CFG_FILTER_GAIN, pick_gain());
            case ($urandom_range(3))
                0:       write_reg(CFG_TAU_INV, 16'h0000);
                1:       write_reg(CFG_TAU_INV, 16'hFFFF);
                default: write_reg(CFG_TAU_INV, 16'($urandom_range(16'hFFFF)));
            endcase
            // Mostly short periods, so that captures and correction runs
            // alternate within a phase; bit 15 is set at random to show it
            // is ignored.
            case ($urandom_range(5))
                0:       write_reg(CFG_DR_PERIOD, {1'($urandom_range(1)), 15'd0});
                1:       write_reg(CFG_DR_PERIOD, {1'($urandom_range(1)), 15'h7FFF});
                default: write_reg(CFG_DR_PERIOD,
                                   {1'($urandom_range(1)), 15'($urandom_range(1, 40))});
            endcase
            cfg_we <= 1'b0;

            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 59;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 59;
                end
                default:
                begin
                    tx_idle_pct  = 11;
                    rx_stall_pct = 11;
                end
            endcase
            // Once, the receiver goes away for a long while with the sender
            // still pushing, so the block fills and holds off its input.
            if (phase == 4)
                hold_request = 1;

            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick(rand_tick(), 0, zero_nav);
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain_and_settle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial
    begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/gipi_pkg.sv
sv/gps_inertial_position_integrator.sv
bench/testbench.sv
